// File: rtl/mhs_pkg.sv
// ---------------------------------------------------------------------------
// mhs_pkg
// Shared types and constants for the magnetometer heading sector block.
// ---------------------------------------------------------------------------
package mhs_pkg;

	// CORDIC datapath: samples are scaled to 30 bits, plus headroom for gain
	localparam int CW        = 33;
	localparam int SCALE_POS = 30;
	// angles in 2^-16 rad, signed
	localparam int AW        = 21;
	localparam int DECL_W    = 19;
	// wrapped angle, unsigned, 0 .. 2*pi
	localparam int HW        = 19;
	localparam int DEG_W     = 9;

	localparam logic signed [AW-1:0]     ANG_PI       = 21'sd205887;
	localparam logic signed [AW-1:0]     ANG_TWO_PI   = 21'sd411775;
	localparam logic signed [DECL_W-1:0] DECL_RESET   = 19'sd5014;

	// degrees = floor(h * DEG_NUM / DEG_DEN)
	localparam longint unsigned DEG_NUM     = 64'd180000;
	localparam longint unsigned DEG_DEN     = 64'd205887416;
	localparam int              RECIP_SHIFT = 32;
	// floor of the reciprocal: estimate is exact or one low
	localparam longint unsigned DEG_RECIP   = (DEG_NUM << RECIP_SHIFT) / DEG_DEN;

	localparam int PROD_W  = 37;  // h * DEG_NUM
	localparam int EST_W   = 41;  // h * DEG_RECIP
	localparam int CHECK_W = 38;  // (q + 1) * DEG_DEN

	localparam logic [DEG_W-1:0] DEG_MAX        = 9'd360;
	localparam logic [DEG_W-1:0] NORTH_LO_END   = 9'd20;
	localparam logic [DEG_W-1:0] NORTH_HI_START = 9'd340;
	localparam logic [DEG_W-1:0] SOUTH_LO       = 9'd160;
	localparam logic [DEG_W-1:0] SOUTH_HI       = 9'd200;
	localparam logic [DEG_W-1:0] EAST_LO        = 9'd70;
	localparam logic [DEG_W-1:0] EAST_HI        = 9'd110;
	localparam logic [DEG_W-1:0] WEST_LO        = 9'd250;
	localparam logic [DEG_W-1:0] WEST_HI        = 9'd290;

	typedef enum logic [2:0] {
		DIR_NORTH = 3'd0,
		DIR_SOUTH = 3'd1,
		DIR_EAST  = 3'd2,
		DIR_WEST  = 3'd3,
		DIR_NONE  = 3'd4
	} dir_t;

	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [AW-1:0] z;
		logic                 zero;
	} cordic_t;

	typedef struct packed {
		logic [DEG_W-1:0] deg;
		dir_t             dir;
	} result_t;

	// atan(2^-i) * 65536, rounded
	function automatic logic [16:0] atan_entry(input int i);
		logic [16:0] r;
		case (i)
			0:       r = 17'd51472;
			1:       r = 17'd30386;
			2:       r = 17'd16055;
			3:       r = 17'd8150;
			4:       r = 17'd4091;
			5:       r = 17'd2047;
			6:       r = 17'd1024;
			7:       r = 17'd512;
			8:       r = 17'd256;
			9:       r = 17'd128;
			10:      r = 17'd64;
			11:      r = 17'd32;
			12:      r = 17'd16;
			13:      r = 17'd8;
			14:      r = 17'd4;
			15:      r = 17'd2;
			16:      r = 17'd1;
			default: r = 17'd0;
		endcase
		return r;
	endfunction

endpackage

// File: rtl/mhs_cordic_stage.sv
// ---------------------------------------------------------------------------
// mhs_cordic_stage
// One registered vectoring CORDIC micro-rotation with a fixed shift.
// ---------------------------------------------------------------------------
module mhs_cordic_stage #(
	parameter int IDX = 0
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_valid,
	input  mhs_pkg::cordic_t in_data,
	output logic             out_valid,
	output mhs_pkg::cordic_t out_data
);
	import mhs_pkg::*;

	logic signed [CW-1:0] x_sh;
	logic signed [CW-1:0] y_sh;
	logic signed [AW-1:0] step;
	cordic_t              nxt;
	logic                 vld_s;
	cordic_t              cs_s;

	always_comb begin
		x_sh = in_data.x >>> IDX;
		y_sh = in_data.y >>> IDX;
		step = $signed(AW'(atan_entry(IDX)));
		nxt  = in_data;
		// y >= 0 rotates clockwise
		if (!in_data.y[CW-1]) begin
			nxt.x = in_data.x + y_sh;
			nxt.y = in_data.y - x_sh;
			nxt.z = in_data.z + step;
		end else begin
			nxt.x = in_data.x - y_sh;
			nxt.y = in_data.y + x_sh;
			nxt.z = in_data.z - step;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= 1'b0;
		end else if (en) begin
			vld_s <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cs_s <= nxt;
		end
	end

	assign out_valid = vld_s;
	assign out_data  = cs_s;

endmodule

// File: rtl/mhs_cordic.sv
// ---------------------------------------------------------------------------
// mhs_cordic
// Quadrant pre-rotation and scaling, then an unrolled chain of CORDIC stages.
// ---------------------------------------------------------------------------
module mhs_cordic #(
	parameter int SAMPLE_BITS   = 16,
	parameter int CORDIC_STAGES = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          in_valid,
	input  logic signed [SAMPLE_BITS-1:0] x_field,
	input  logic signed [SAMPLE_BITS-1:0] y_field,
	output logic                          out_valid,
	output mhs_pkg::cordic_t              out_data
);
	import mhs_pkg::*;

	localparam int GUARD = SCALE_POS - SAMPLE_BITS;

	logic signed [CW-1:0] x_ext;
	logic signed [CW-1:0] y_ext;
	cordic_t              pre;
	logic                 vld_s0;
	cordic_t              pre_s0;

	logic    vld [CORDIC_STAGES+1];
	cordic_t stg [CORDIC_STAGES+1];

	always_comb begin
		x_ext    = CW'(x_field);
		y_ext    = CW'(y_field);
		pre.zero = (x_field == '0) && (y_field == '0);
		pre.z    = '0;
		// left half plane: turn by 180 degrees, start at +-pi
		if (x_field[SAMPLE_BITS-1]) begin
			x_ext = -x_ext;
			y_ext = -y_ext;
			pre.z = y_field[SAMPLE_BITS-1] ? -ANG_PI : ANG_PI;
		end
		pre.x = x_ext <<< GUARD;
		pre.y = y_ext <<< GUARD;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s0 <= 1'b0;
		end else if (en) begin
			vld_s0 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pre_s0 <= pre;
		end
	end

	assign vld[0] = vld_s0;
	assign stg[0] = pre_s0;

	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
		mhs_cordic_stage #(
			.IDX (i)
		) u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.in_valid  (vld[i]),
			.in_data   (stg[i]),
			.out_valid (vld[i+1]),
			.out_data  (stg[i+1])
		);
	end

	assign out_valid = vld[CORDIC_STAGES];
	assign out_data  = stg[CORDIC_STAGES];

endmodule

// File: rtl/mhs_degrees.sv
// ---------------------------------------------------------------------------
// mhs_degrees
// Adds declination, wraps into 0..2*pi, converts to degrees, picks sector.
// ---------------------------------------------------------------------------
module mhs_degrees (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             en,
	input  logic                             in_valid,
	input  mhs_pkg::cordic_t                 in_data,
	input  logic signed [mhs_pkg::DECL_W-1:0] decl,
	output logic                             out_valid,
	output mhs_pkg::result_t                 out_data
);
	import mhs_pkg::*;

	logic                 vld_s1, vld_s2, vld_s3, vld_s4;
	logic signed [AW-1:0] h_s1;
	logic [HW-1:0]        hw_s2;
	logic [PROD_W-1:0]    p_s3, p_s4;
	logic [DEG_W-1:0]     q0_s3, q0_s4;
	logic [CHECK_W-1:0]   t_s4;

	logic signed [AW-1:0] z_in;
	logic signed [AW-1:0] h_a;
	logic signed [AW-1:0] h_b;
	logic [EST_W-1:0]     est;
	logic [DEG_W:0]       q_inc;
	logic [DEG_W-1:0]     deg;

	always_comb begin
		z_in = in_data.zero ? '0 : in_data.z;
		// one wrap each way, then clamp at zero
		h_a  = (h_s1 > ANG_TWO_PI) ? h_s1 - ANG_TWO_PI : h_s1;
		h_b  = h_a[AW-1] ? h_a + ANG_TWO_PI : h_a;
		if (h_b[AW-1]) begin
			h_b = '0;
		end
		est   = EST_W'(hw_s2) * EST_W'(DEG_RECIP);
		q_inc = (DEG_W+1)'(q0_s4) + 1'b1;
		deg   = (CHECK_W'(p_s4) >= t_s4) ? q_inc[DEG_W-1:0] : q0_s4;
		if (q_inc > (DEG_W+1)'(DEG_MAX) && CHECK_W'(p_s4) >= t_s4) begin
			deg = DEG_MAX;
		end
		out_data.deg = deg;
		if (deg <= NORTH_LO_END || deg >= NORTH_HI_START) begin
			out_data.dir = DIR_NORTH;
		end else if (deg >= SOUTH_LO && deg <= SOUTH_HI) begin
			out_data.dir = DIR_SOUTH;
		end else if (deg >= EAST_LO && deg <= EAST_HI) begin
			out_data.dir = DIR_EAST;
		end else if (deg >= WEST_LO && deg <= WEST_HI) begin
			out_data.dir = DIR_WEST;
		end else begin
			out_data.dir = DIR_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			h_s1  <= z_in + AW'(decl);
			hw_s2 <= h_b[HW-1:0];
			p_s3  <= PROD_W'(hw_s2) * PROD_W'(DEG_NUM);
			q0_s3 <= est[RECIP_SHIFT +: DEG_W];
			p_s4  <= p_s3;
			q0_s4 <= q0_s3;
			// estimate is exact or one low; this product settles which
			t_s4  <= CHECK_W'(CHECK_W'(q0_s3) + 1'b1) * CHECK_W'(DEG_DEN);
		end
	end

	assign out_valid = vld_s4;

endmodule

// File: rtl/mhs_outbuf.sv
// ---------------------------------------------------------------------------
// mhs_outbuf
// Output register plus skid entry; stall toward the pipeline is registered.
// ---------------------------------------------------------------------------
module mhs_outbuf (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  mhs_pkg::result_t in_data,
	output logic             advance,
	output logic             out_valid,
	input  logic             out_ready,
	output mhs_pkg::result_t out_data
);
	import mhs_pkg::*;

	logic    out_vld_q;
	logic    skid_vld_q;
	result_t out_q;
	result_t skid_q;
	logic    take;

	assign take    = out_vld_q && out_ready;
	assign advance = !skid_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (skid_vld_q) begin
			if (take) begin
				skid_vld_q <= 1'b0;
			end
		end else if (in_valid) begin
			if (!out_vld_q || take) begin
				out_vld_q <= 1'b1;
			end else begin
				skid_vld_q <= 1'b1;
			end
		end else if (take) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_vld_q) begin
			if (take) begin
				out_q <= skid_q;
			end
		end else if (in_valid) begin
			if (!out_vld_q || take) begin
				out_q <= in_data;
			end else begin
				skid_q <= in_data;
			end
		end
	end

	assign out_valid = out_vld_q;
	assign out_data  = out_q;

endmodule

// File: rtl/magnetometer_heading_sector.sv
// ---------------------------------------------------------------------------
// magnetometer_heading_sector
// Compass heading in whole degrees and a compass sector from one X/Y sample.
// ---------------------------------------------------------------------------
// Use:
//   in channel  (in_valid/in_ready, x_field, y_field): one request per sample.
//   out channel (out_valid/out_ready, heading_degrees, direction): one result
//   per sample, in order.
//   cfg channel (cfg_valid/cfg_ready, declination): cfg_ready is always high;
//   write only while no sample is in flight.
// Path: the pre-rotation register takes the request, then CORDIC_STAGES
//   micro-rotations, declination add, wrap, two multiply stages for the
//   degree conversion, output register.
// Throughput: one sample per cycle while in_ready is high; every stage ahead
//   of the output buffer is a register on a shared advance enable.
// Stall: when out_ready is low the next finished result parks in a one-entry
//   skid; once it is occupied in_ready drops and the whole pipe holds, so
//   nothing is lost or repeated. in_ready is a register output.
// Reset: valid bits clear, pipe is empty, in_ready is high, declination
//   returns to 5014 (about 0.0765 rad).
// ---------------------------------------------------------------------------
module magnetometer_heading_sector #(
	parameter int SAMPLE_BITS   = 16,
	parameter int CORDIC_STAGES = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// sample request
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic signed [SAMPLE_BITS-1:0]    x_field,
	input  logic signed [SAMPLE_BITS-1:0]    y_field,
	// result request
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [mhs_pkg::DEG_W-1:0]        heading_degrees,
	output logic [2:0]                       direction,
	// declination register write
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic signed [mhs_pkg::DECL_W-1:0] declination
);
	import mhs_pkg::*;

	logic                     advance;
	logic                     cor_valid;
	cordic_t                  cor_data;
	logic                     deg_valid;
	result_t                  deg_data;
	result_t                  res;
	logic signed [DECL_W-1:0] decl_q;

	// register write; the user must keep the pipe idle whenever this happens, the block does not enforce it
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decl_q <= DECL_RESET;
		end else if (cfg_valid && cfg_ready) begin
			decl_q <= declination;
		end
	end

	// the whole pipe moves whenever the skid entry is free
	assign in_ready = advance;

	mhs_cordic #(
		.SAMPLE_BITS   (SAMPLE_BITS),
		.CORDIC_STAGES (CORDIC_STAGES)
	) u_cordic (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (advance),
		.in_valid  (in_valid),
		.x_field   (x_field),
		.y_field   (y_field),
		.out_valid (cor_valid),
		.out_data  (cor_data)
	);

	mhs_degrees u_degrees (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (advance),
		.in_valid  (cor_valid),
		.in_data   (cor_data),
		.decl      (decl_q),
		.out_valid (deg_valid),
		.out_data  (deg_data)
	);

	mhs_outbuf u_outbuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (deg_valid),
		.in_data   (deg_data),
		.advance   (advance),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (res)
	);

	assign heading_degrees = res.deg;
	assign direction       = res.dir;

endmodule

// File: rtl/mhs_checker.sv
// ---------------------------------------------------------------------------
// mhs_checker
// Port-level checks for the heading block, bound to the top level.
// ---------------------------------------------------------------------------
module mhs_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_ready,
	input logic                      out_valid,
	input logic                      out_ready,
	input logic [mhs_pkg::DEG_W-1:0] heading_degrees,
	input logic [2:0]                direction
);
	import mhs_pkg::*;

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(heading_degrees) && $stable(direction))
		else $error("result changed while stalled");

	a_deg_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> heading_degrees <= DEG_MAX)
		else $error("heading above 360");

	a_north: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((direction == DIR_NORTH) ==
			(heading_degrees <= NORTH_LO_END || heading_degrees >= NORTH_HI_START)))
		else $error("north sector mismatch");

	// back-pressure toward the input only follows a stalled output
	a_ready_drop: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(in_ready) |-> $past(out_valid && !out_ready))
		else $error("in_ready fell without an output stall");

endmodule

bind magnetometer_heading_sector mhs_checker u_mhs_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_ready        (in_ready),
	.out_valid       (out_valid),
	.out_ready       (out_ready),
	.heading_degrees (heading_degrees),
	.direction       (direction)
);
